>>> rtl/affine_matrix_decompose_defines.svh
// Assertion macros used by the checker file.
`ifndef AFFINE_MATRIX_DECOMPOSE_DEFINES_SVH
`define AFFINE_MATRIX_DECOMPOSE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define AMD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication.
`define AMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

>>> rtl/amd_pkg.sv
// ----------------------------------------------------------------------------
// amd_pkg
// Shared constants, command codes and types of the affine decomposer.
// ----------------------------------------------------------------------------
package amd_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int UNIT_BITS        = 30;
   localparam int STEP_W           = 5;
   localparam int SQRT_STEPS       = 32;
   localparam int DIV_STEPS        = 31;
   localparam int ANG_W            = 19;

   localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD_ROW  = 4'd1;
   localparam logic [3:0] OP_LOAD_T    = 4'd2;
   localparam logic [3:0] OP_MAC       = 4'd3;
   localparam logic [3:0] OP_SQ_INIT   = 4'd4;
   localparam logic [3:0] OP_SQ_STEP   = 4'd5;
   localparam logic [3:0] OP_SQ_END    = 4'd6;
   localparam logic [3:0] OP_DIV_INIT  = 4'd7;
   localparam logic [3:0] OP_DIV_STEP  = 4'd8;
   localparam logic [3:0] OP_DIV_END   = 4'd9;
   localparam logic [3:0] OP_COR_INIT  = 4'd10;
   localparam logic [3:0] OP_COR_STEP  = 4'd11;
   localparam logic [3:0] OP_COR_END   = 4'd12;
   localparam logic [3:0] OP_OUT_LOAD  = 4'd13;

   localparam logic [1:0] ANG_Y = 2'd0;
   localparam logic [1:0] ANG_X = 2'd1;
   localparam logic [1:0] ANG_Z = 2'd2;

   typedef struct packed {
      logic [3:0]        op;
      logic [1:0]        row;
      logic [1:0]        col;
      logic [STEP_W-1:0] step;
      logic [1:0]        ang;
      logic              ysq;
      logic              fail;
   } cmd_type;

   typedef struct packed {
      logic in_last;
      logic in_zero;
      logic out_free;
   } stat_type;

   // truncated atan(2^-i) in Q30
   function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/amd_ctrl.sv
// ----------------------------------------------------------------------------
// amd_ctrl
// Sequencer: issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module amd_ctrl #(
   parameter int CORDIC_STEPS = amd_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  amd_pkg::stat_type  stat,
   output amd_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MAC  = 4'd1;
   localparam logic [3:0] S_SQI  = 4'd2;
   localparam logic [3:0] S_SQS  = 4'd3;
   localparam logic [3:0] S_SQE  = 4'd4;
   localparam logic [3:0] S_DVI  = 4'd5;
   localparam logic [3:0] S_DVS  = 4'd6;
   localparam logic [3:0] S_DVE  = 4'd7;
   localparam logic [3:0] S_CRI  = 4'd8;
   localparam logic [3:0] S_CRS  = 4'd9;
   localparam logic [3:0] S_CRE  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   localparam logic [amd_pkg::STEP_W-1:0] SQ_LAST  = amd_pkg::STEP_W'(amd_pkg::SQRT_STEPS - 1);
   localparam logic [amd_pkg::STEP_W-1:0] DIV_LAST = amd_pkg::STEP_W'(amd_pkg::DIV_STEPS - 1);
   localparam logic [amd_pkg::STEP_W-1:0] COR_LAST = amd_pkg::STEP_W'(CORDIC_STEPS - 1);

   logic [3:0]                 state_ff, state_in;
   logic [1:0]                 row_ff, row_in;
   logic [1:0]                 col_ff, col_in;
   logic [amd_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0]                 ang_ff, ang_in;
   logic                       ysq_ff, ysq_in;
   logic                       fail_ff, fail_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      step_in  = step_ff;
      ang_in   = ang_ff;
      ysq_in   = ysq_ff;
      fail_in  = fail_ff;
      cmd.op   = amd_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (stat.in_last) begin
                  cmd.op  = amd_pkg::OP_LOAD_T;
                  fail_in = stat.in_zero;
                  row_in  = 2'd0;
                  col_in  = 2'd0;
                  ysq_in  = 1'b0;
                  state_in = stat.in_zero ? S_OUT : S_MAC;
               end else begin
                  cmd.op = amd_pkg::OP_LOAD_ROW;
               end
            end
         end
         S_MAC: begin
            cmd.op = amd_pkg::OP_MAC;
            if (col_ff == 2'd2) begin
               col_in   = 2'd0;
               state_in = S_SQI;
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         S_SQI: begin
            cmd.op   = amd_pkg::OP_SQ_INIT;
            step_in  = '0;
            state_in = S_SQS;
         end
         S_SQS: begin
            cmd.op = amd_pkg::OP_SQ_STEP;
            if (step_ff == SQ_LAST) state_in = S_SQE;
            else step_in = step_ff + 1'b1;
         end
         S_SQE: begin
            cmd.op = amd_pkg::OP_SQ_END;
            if (ysq_ff) begin
               ang_in   = amd_pkg::ANG_Y;
               state_in = S_CRI;
            end else begin
               col_in   = 2'd0;
               state_in = S_DVI;
            end
         end
         S_DVI: begin
            cmd.op   = amd_pkg::OP_DIV_INIT;
            step_in  = '0;
            state_in = S_DVS;
         end
         S_DVS: begin
            cmd.op = amd_pkg::OP_DIV_STEP;
            if (step_ff == DIV_LAST) state_in = S_DVE;
            else step_in = step_ff + 1'b1;
         end
         S_DVE: begin
            cmd.op = amd_pkg::OP_DIV_END;
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               if (row_ff == 2'd2) begin
                  ysq_in   = 1'b1;
                  state_in = S_SQI;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = S_MAC;
               end
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = S_DVI;
            end
         end
         S_CRI: begin
            cmd.op   = amd_pkg::OP_COR_INIT;
            step_in  = '0;
            state_in = S_CRS;
         end
         S_CRS: begin
            cmd.op = amd_pkg::OP_COR_STEP;
            if (step_ff == COR_LAST) state_in = S_CRE;
            else step_in = step_ff + 1'b1;
         end
         S_CRE: begin
            cmd.op = amd_pkg::OP_COR_END;
            if (ang_ff == amd_pkg::ANG_Z) state_in = S_OUT;
            else begin
               ang_in   = ang_ff + 2'd1;
               state_in = S_CRI;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.op   = amd_pkg::OP_OUT_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.row  = row_ff;
      cmd.col  = col_ff;
      cmd.step = step_ff;
      cmd.ang  = ang_ff;
      cmd.ysq  = ysq_ff;
      cmd.fail = fail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         step_ff  <= '0;
         ang_ff   <= '0;
         ysq_ff   <= 1'b0;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
         ang_ff   <= ang_in;
         ysq_ff   <= ysq_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

>>> rtl/amd_datapath.sv
// ----------------------------------------------------------------------------
// amd_datapath
// Row store, shared multiplier, sqrt/divide/CORDIC unit, output register.
// ----------------------------------------------------------------------------
module amd_datapath #(
   parameter int FRAC_BITS = amd_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  amd_pkg::cmd_type  cmd,
   output amd_pkg::stat_type stat,
   input  logic [127:0]      req_tdata,
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [247:0]      rsp_tdata,
   output logic [0:0]        rsp_tuser
);

   localparam int RND_SH = amd_pkg::UNIT_BITS - FRAC_BITS;
   localparam logic signed [34:0] RND_ADD = 35'sd1 <<< (RND_SH - 1);
   localparam logic signed [31:0] ONE_Q30 = 32'sd1 <<< amd_pkg::UNIT_BITS;

   logic signed [31:0] rows_ff [9];
   logic signed [31:0] n_ff [9];
   logic [31:0]        len_ff [3];
   logic signed [31:0] tr_ff [3];
   logic [63:0]        acc_ff;
   logic [63:0]        rad_ff;
   logic [33:0]        srem_ff;
   logic [31:0]        root_ff;
   logic [31:0]        tmp_ff;
   logic [31:0]        drem_ff;
   logic [30:0]        dq_ff;
   logic               dbit_ff, dneg_ff, dfirst_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [34:0] cz_ff;
   logic               czero_ff;
   logic [18:0]        rot_ff [3];
   logic               rsp_valid_ff;
   logic [247:0]       rsp_data_ff;
   logic               rsp_ok_ff;

   logic signed [31:0] col_in [4];
   logic [3:0]         rd_idx, wr_base;
   logic signed [31:0] rd_val, mul_a;
   logic signed [63:0] prod;
   logic [35:0]        srem_n, strial;
   logic [32:0]        drem_n;
   logic [31:0]        den, mag;
   logic [30:0]        dq_fin;
   logic               gimbal;
   logic signed [31:0] oy, ox;
   logic signed [33:0] dx, dy;
   logic signed [34:0] zc, zr;
   logic [30:0]        sc [3];

   always_comb begin
      for (int k = 0; k < 4; k++) col_in[k] = req_tdata[32*k +: 32];
   end

   assign stat.in_last  = (req_tuser == 2'd3);
   assign stat.in_zero  = (req_tdata[127:96] == 32'd0);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign rd_idx  = ({2'b00, cmd.row} << 1) + {2'b00, cmd.row} + {2'b00, cmd.col};
   assign wr_base = ({2'b00, req_tuser} << 1) + {2'b00, req_tuser};
   assign rd_val  = rows_ff[rd_idx];
   assign den     = len_ff[cmd.row];
   assign mag     = rd_val[31] ? (~rd_val + 32'd1) : rd_val;

   // one shared multiplier: row squares, or n0z squared for the asin leg
   assign mul_a = (cmd.op == amd_pkg::OP_MAC) ? rd_val : n_ff[2];
   assign prod  = mul_a * mul_a;

   assign srem_n = {srem_ff, rad_ff[63:62]};
   assign strial = {2'b00, root_ff, 2'b01};
   assign drem_n = {drem_ff, (dfirst_ff ? dbit_ff : 1'b0)};
   assign dq_fin = (den == 32'd0) ? 31'd0 : dq_ff;

   assign gimbal = (n_ff[2] == ONE_Q30) || (n_ff[2] == -ONE_Q30);

   always_comb begin
      case (cmd.ang)
         amd_pkg::ANG_Y: begin
            oy = -n_ff[2];
            ox = tmp_ff;
         end
         amd_pkg::ANG_X: begin
            oy = gimbal ? -n_ff[6] : n_ff[5];
            ox = gimbal ? n_ff[4] : n_ff[8];
         end
         amd_pkg::ANG_Z: begin
            oy = gimbal ? 32'sd0 : n_ff[1];
            ox = gimbal ? 32'sd0 : n_ff[0];
         end
         default: begin
            oy = 32'sd0;
            ox = 32'sd0;
         end
      endcase
   end

   assign dx = cx_ff >>> cmd.step;
   assign dy = cy_ff >>> cmd.step;

   always_comb begin
      zc = cz_ff;
      if (zc > amd_pkg::PI_Q30) zc = amd_pkg::PI_Q30;
      if (zc < -amd_pkg::PI_Q30) zc = -amd_pkg::PI_Q30;
      zr = (zc + RND_ADD) >>> RND_SH;
      for (int k = 0; k < 3; k++) begin
         sc[k] = len_ff[k][31] ? 31'h7FFF_FFFF : len_ff[k][30:0];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         amd_pkg::OP_LOAD_ROW: begin
            for (int k = 0; k < 3; k++) rows_ff[wr_base + 4'(k)] <= col_in[k];
         end
         amd_pkg::OP_LOAD_T: begin
            for (int k = 0; k < 3; k++) tr_ff[k] <= col_in[k];
         end
         amd_pkg::OP_MAC: begin
            acc_ff <= ((cmd.col == 2'd0) ? 64'd0 : acc_ff) + prod;
         end
         amd_pkg::OP_SQ_INIT: begin
            rad_ff  <= cmd.ysq ? ((64'd1 << 60) - prod) : acc_ff;
            srem_ff <= '0;
            root_ff <= '0;
         end
         amd_pkg::OP_SQ_STEP: begin
            rad_ff <= rad_ff << 2;
            if (srem_n >= strial) begin
               srem_ff <= 34'(srem_n - strial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= srem_n[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         amd_pkg::OP_SQ_END: begin
            if (cmd.ysq) tmp_ff <= root_ff;
            else len_ff[cmd.row] <= root_ff;
         end
         amd_pkg::OP_DIV_INIT: begin
            drem_ff   <= {1'b0, mag[31:1]};
            dbit_ff   <= mag[0];
            dneg_ff   <= rd_val[31];
            dfirst_ff <= 1'b1;
            dq_ff     <= '0;
         end
         amd_pkg::OP_DIV_STEP: begin
            dfirst_ff <= 1'b0;
            if (drem_n >= {1'b0, den}) begin
               drem_ff <= 32'(drem_n - {1'b0, den});
               dq_ff   <= {dq_ff[29:0], 1'b1};
            end else begin
               drem_ff <= drem_n[31:0];
               dq_ff   <= {dq_ff[29:0], 1'b0};
            end
         end
         amd_pkg::OP_DIV_END: begin
            n_ff[rd_idx] <= dneg_ff ? -$signed({1'b0, dq_fin}) : $signed({1'b0, dq_fin});
         end
         amd_pkg::OP_COR_INIT: begin
            czero_ff <= (ox == 32'sd0) && (oy == 32'sd0);
            if (ox < 0) begin
               cx_ff <= -34'(ox);
               cy_ff <= -34'(oy);
               cz_ff <= (oy >= 0) ? amd_pkg::PI_Q30 : -amd_pkg::PI_Q30;
            end else begin
               cx_ff <= 34'(ox);
               cy_ff <= 34'(oy);
               cz_ff <= '0;
            end
         end
         amd_pkg::OP_COR_STEP: begin
            if (cy_ff >= 0) begin
               cx_ff <= cx_ff + dy;
               cy_ff <= cy_ff - dx;
               cz_ff <= cz_ff + $signed({5'b0, amd_pkg::atan_entry(cmd.step)});
            end else begin
               cx_ff <= cx_ff - dy;
               cy_ff <= cy_ff + dx;
               cz_ff <= cz_ff - $signed({5'b0, amd_pkg::atan_entry(cmd.step)});
            end
         end
         amd_pkg::OP_COR_END: begin
            rot_ff[cmd.ang] <= czero_ff ? 19'd0 : zr[18:0];
         end
         default: ;
      endcase
   end

   // result register; a finished beat waits here while rows keep coming
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == amd_pkg::OP_OUT_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // angles are stored by solve order (y, x, z); the beat carries x, y, z
   always_ff @(posedge clock) begin
      if (cmd.op == amd_pkg::OP_OUT_LOAD) begin
         rsp_ok_ff <= !cmd.fail;
         if (cmd.fail) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {2'b00, sc[2], sc[1], sc[0],
                            rot_ff[amd_pkg::ANG_Z], rot_ff[amd_pkg::ANG_Y],
                            rot_ff[amd_pkg::ANG_X],
                            tr_ff[2], tr_ff[1], tr_ff[0]};
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_ok_ff;

endmodule

>>> rtl/affine_matrix_decompose.sv
// ----------------------------------------------------------------------------
// affine_matrix_decompose
// 4x4 transform to translation, Euler rotation and scale, fixed point.
// ----------------------------------------------------------------------------
//
// channel | dir | beat contents
// --------+-----+----------------------------------------------------------
// req_    | in  | one matrix row: row_index in tuser, col_0..col_3 in tdata
// rsp_    | out | one decomposition per row 3 beat: ok in tuser, rest tdata
//
// Rows 0..2 are stored as they arrive. A row 3 beat starts the solve:
// per row 3 MACs, a sqrt and 3 divides, then a sqrt and three CORDIC
// runs, all on the single shared sqrt/divide/CORDIC unit. A zero m33
// skips the solve and yields a failed beat.
// Synchronous active-high reset clears control only; the row store holds
// garbage until written. req_tready drops while a row 3 beat is worked on;
// a finished beat waits in the output register without blocking rows.
// ----------------------------------------------------------------------------
module affine_matrix_decompose #(
   parameter int FRAC_BITS    = amd_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = amd_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // col_0[31:0], col_1[63:32], col_2[95:64], col_3[127:96]
   input  logic [127:0] req_tdata,
   // row_index[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // trans_x[31:0], trans_y[63:32], trans_z[95:64], rot_x[114:96],
   // rot_y[133:115], rot_z[152:134], scale_x[183:153], scale_y[214:184],
   // scale_z[245:215], zero pad[247:246]
   output logic [247:0] rsp_tdata,
   // ok[0]
   output logic [0:0]   rsp_tuser
);

   amd_pkg::cmd_type  cmd;   // per-cycle datapath command
   amd_pkg::stat_type stat;  // input decode and output space

   amd_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   amd_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/amd_checker.sv
// ----------------------------------------------------------------------------
// amd_checker
// Port-level checks of the decomposer, bound to the top level.
// ----------------------------------------------------------------------------
`include "affine_matrix_decompose_defines.svh"

module amd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [247:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   `AMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AMD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // a failed decomposition carries all-zero fields
   `AMD_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 248'd0)
   // a row 3 beat occupies the unit, so the next cycle takes no row
   `AMD_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready && req_tuser == 2'd3, !req_tready)

endmodule

bind affine_matrix_decompose amd_checker u_amd_checker (.*);
